// ----- design/assert_macros.svh -----
// Assertion macros used by the button classifier top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define DBPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define DBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/dbpc_pkg.sv -----
// Types and constants for the debounced button press classifier.
package dbpc_pkg;

    localparam int unsigned TS_W     = 32;
    localparam int unsigned DEB_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;

    typedef logic [1:0] t_event;

    localparam t_event EV_NONE      = 2'd0;
    localparam t_event EV_SHORT     = 2'd1;
    localparam t_event EV_LONG      = 2'd2;
    localparam t_event EV_VERY_LONG = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_ACTIVE_LEVEL  = 8'd0;
    localparam t_cfg_idx REG_DEBOUNCE_TIME = 8'd1;
    localparam t_cfg_idx REG_LONG_THRESH   = 8'd2;
    localparam t_cfg_idx REG_VLONG_THRESH  = 8'd3;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [TS_W-1:0]  LONG_THRESH_RST  = 32'd1000;
    localparam logic [TS_W-1:0]  VLONG_THRESH_RST = 32'd3000;

    typedef struct packed {
        logic              active_level;
        logic [DEB_W-1:0]  debounce_time;
        logic [TS_W-1:0]   long_threshold;
        logic [TS_W-1:0]   very_long_threshold;
    } t_cfg;

    typedef struct packed {
        t_event            event_code;
        logic              pressed_now;
        logic [TS_W-1:0]   held_duration;
    } t_result;

endpackage

// ----- design/dbpc_cfg_regs.sv -----
// Configuration register file for the button classifier.
module dbpc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  dbpc_pkg::t_cfg_idx         i_cfg_index,
    input  logic [dbpc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output dbpc_pkg::t_cfg             o_cfg
);

    dbpc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level        <= 1'b0;
            r_cfg.debounce_time       <= dbpc_pkg::DEBOUNCE_RST;
            r_cfg.long_threshold      <= dbpc_pkg::LONG_THRESH_RST;
            r_cfg.very_long_threshold <= dbpc_pkg::VLONG_THRESH_RST;
        end else if (i_cfg_valid) begin
            // unknown indexes are dropped
            unique case (i_cfg_index)
                dbpc_pkg::REG_ACTIVE_LEVEL:  r_cfg.active_level <= i_cfg_data[0];
                dbpc_pkg::REG_DEBOUNCE_TIME: begin
                    r_cfg.debounce_time <= i_cfg_data[dbpc_pkg::DEB_W-1:0];
                end
                dbpc_pkg::REG_LONG_THRESH:   r_cfg.long_threshold <= i_cfg_data;
                dbpc_pkg::REG_VLONG_THRESH:  r_cfg.very_long_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/dbpc_core.sv -----
// Debounce state and press classification for one sample beat.
module dbpc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dbpc_pkg::t_cfg                i_cfg,
    input  logic                          i_advance,
    input  logic                          i_pin_level,
    input  logic [dbpc_pkg::TS_W-1:0]     i_now_ms,
    output dbpc_pkg::t_result             o_result
);

    logic                      r_stable;
    logic                      r_last_sample;
    logic [dbpc_pkg::TS_W-1:0] r_change_time;
    logic [dbpc_pkg::TS_W-1:0] r_press_start;

    logic                      n_stable;
    logic                      n_last_sample;
    logic [dbpc_pkg::TS_W-1:0] n_change_time;
    logic [dbpc_pkg::TS_W-1:0] n_press_start;

    logic                      sample;
    logic [dbpc_pkg::TS_W-1:0] since_change;
    logic [dbpc_pkg::TS_W-1:0] held;
    logic                      settled;
    logic                      press_edge;
    logic                      release_edge;
    dbpc_pkg::t_event          code;

    assign sample       = (i_pin_level == i_cfg.active_level);
    assign since_change = i_now_ms - r_change_time;
    assign held         = i_now_ms - r_press_start;
    assign settled      = (sample == r_last_sample) &&
                          (since_change >= {{(dbpc_pkg::TS_W-dbpc_pkg::DEB_W){1'b0}},
                                            i_cfg.debounce_time}) &&
                          (sample != r_stable);
    assign press_edge   = settled && sample;
    assign release_edge = settled && !sample;

    always_comb begin
        n_last_sample = sample;
        n_change_time = (sample != r_last_sample) ? i_now_ms : r_change_time;
        n_stable      = settled ? sample : r_stable;
        n_press_start = r_press_start;
        if (press_edge) begin
            n_press_start = i_now_ms;
        end else if (release_edge) begin
            n_press_start = '0;
        end
    end

    // very long tested first, even with thresholds out of order
    always_comb begin
        priority if (!release_edge) begin
            code = dbpc_pkg::EV_NONE;
        end else if (held >= i_cfg.very_long_threshold) begin
            code = dbpc_pkg::EV_VERY_LONG;
        end else if (held >= i_cfg.long_threshold) begin
            code = dbpc_pkg::EV_LONG;
        end else begin
            code = dbpc_pkg::EV_SHORT;
        end
    end

    always_comb begin
        o_result.event_code    = code;
        o_result.pressed_now   = n_stable;
        // zero start tick means no press recorded
        o_result.held_duration = (n_stable && !press_edge && (r_press_start != '0)) ?
                                 held : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b0;
            r_last_sample <= 1'b0;
            r_change_time <= '0;
            r_press_start <= '0;
        end else if (i_advance) begin
            r_stable      <= n_stable;
            r_last_sample <= n_last_sample;
            r_change_time <= n_change_time;
            r_press_start <= n_press_start;
        end
    end

endmodule

// ----- design/debounced_button_press_classifier.sv -----
// Top level of the debounced button press classifier.
// A beat passes from the input register through the core into the result register.
// One beat per cycle unless the output stalls; the input register then holds one beat.
// Reset: synchronous, active low; button assumed released, timers and start tick cleared,
// configuration back to active level 0, debounce 50, thresholds 1000 and 3000.
`include "assert_macros.svh"

module debounced_button_press_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_pin_level,
    input  logic [dbpc_pkg::TS_W-1:0]      i_now_ms,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dbpc_pkg::t_event               o_event_code,
    output logic                           o_pressed_now,
    output logic [dbpc_pkg::TS_W-1:0]      o_held_duration,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  dbpc_pkg::t_cfg_idx             i_cfg_index,
    input  logic [dbpc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    dbpc_pkg::t_cfg            cfg;
    dbpc_pkg::t_result         core_result;

    // input register
    logic                      r_in_valid;
    logic                      r_in_pin;
    logic [dbpc_pkg::TS_W-1:0] r_in_now;

    // result register
    logic                      r_out_valid;
    dbpc_pkg::t_result         r_out;

    logic                      out_free;
    logic                      advance;
    logic                      in_take;

    // config writes never wait
    assign o_cfg_ready = 1'b1;

    dbpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // result register can load when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    // beat in the input register moves through the core and into the result register
    assign advance    = r_in_valid && out_free;
    // input register takes a beat when empty or emptying
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    dbpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_advance   (advance),
        .i_pin_level (r_in_pin),
        .i_now_ms    (r_in_now),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pin <= i_pin_level;
            r_in_now <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_code    = r_out.event_code;
    assign o_pressed_now   = r_out.pressed_now;
    assign o_held_duration = r_out.held_duration;

    // a classified release always leaves the button released
    `DBPC_ASSERT_NOW(a_event_released, r_out_valid && (r_out.event_code != dbpc_pkg::EV_NONE), !r_out.pressed_now, "event with pressed state")
    // a running duration only exists while pressed
    `DBPC_ASSERT_NOW(a_dur_pressed, r_out_valid && (r_out.held_duration != '0), r_out.pressed_now, "duration while released")
    // stall toward the source only when a beat is already held
    `DBPC_ASSERT_NOW(a_stall_held, o_in_stall, r_in_valid && r_out_valid, "stall without held beat")
    // a held beat with a free result register lands there in the next cycle
    `DBPC_ASSERT_NEXT(a_advance_lands, advance, r_out_valid, "advanced beat lost")

endmodule

// ----- tb/debounced_button_press_classifier_tb.sv -----
// Self-checking testbench for the debounced button press classifier.
`timescale 1ns / 100ps

module debounced_button_press_classifier_tb;

    import dbpc_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 150;    // long receiver hold-off for the pressure phase
    localparam int DRAIN_CYCLES = 6;      // margin for the input and result registers to drain
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_BEATS  = 130;

    // First index past the register file; writes there must be ignored.
    localparam t_cfg_idx REG_UNUSED = 8'd4;

    typedef struct {
        logic            pin;
        logic [TS_W-1:0] now;
    } t_pin_sample;

    // Block ports; every input starts at a known value.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic                 i_pin_level     = 1'b0;
    logic [TS_W-1:0]      i_now_ms        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    t_event               o_event_code;
    logic                 o_pressed_now;
    logic [TS_W-1:0]      o_held_duration;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;

    // Predictor copy of the configuration, starting from the reset values.
    logic                 cfg_active   = 1'b0;
    logic [DEB_W-1:0]     cfg_debounce = DEBOUNCE_RST;
    logic [TS_W-1:0]      cfg_long     = LONG_THRESH_RST;
    logic [TS_W-1:0]      cfg_vlong    = VLONG_THRESH_RST;

    // Predictor copy of the debounce state. Button assumed released after reset.
    logic                 stable_pressed = 1'b0;
    logic                 last_pressed   = 1'b0;
    logic [TS_W-1:0]      change_ms      = '0;
    logic [TS_W-1:0]      start_ms       = '0;

    t_pin_sample          sample_q[$];         // samples waiting to be offered
    t_result              expected_q[$];       // predicted results, oldest first

    int                   send_idle_pct  = 0;
    int                   stall_pct      = 0;
    logic                 out_hold       = 1'b0;
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    logic [TS_W-1:0]      gen_ms         = '0;  // running timestamp of the generator

    event                 hold_start;

    debounced_button_press_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pin_level     (i_pin_level),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_code    (o_event_code),
        .o_pressed_now   (o_pressed_now),
        .o_held_duration (o_held_duration),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Debounce and classify one accepted sample, advancing the predictor state.
    // A flag change only restarts the timer; the stable state can move on a later
    // sample of the same flag once it has held for the debounce time.
    function automatic t_result classify_sample(logic pin, logic [TS_W-1:0] now);
        t_result         r;
        logic            pressed;
        logic [TS_W-1:0] since_change;
        logic [TS_W-1:0] deb_wide;
        logic [TS_W-1:0] held;
        pressed      = (pin == cfg_active);
        since_change = now - change_ms;
        deb_wide     = TS_W'(cfg_debounce);
        r.event_code = EV_NONE;
        if (pressed != last_pressed) begin
            last_pressed = pressed;
            change_ms    = now;
        end else if (since_change >= deb_wide && pressed != stable_pressed) begin
            stable_pressed = pressed;
            if (pressed) begin
                start_ms = now;
            end else begin
                // Duration wraps modulo 2^32; very long is tested first even
                // when the thresholds are out of order.
                held     = now - start_ms;
                start_ms = '0;
                if (held >= cfg_vlong) begin
                    r.event_code = EV_VERY_LONG;
                end else if (held >= cfg_long) begin
                    r.event_code = EV_LONG;
                end else begin
                    r.event_code = EV_SHORT;
                end
            end
        end
        r.pressed_now = stable_pressed;
        // A start tick of 0 means no press recorded: duration reads 0.
        r.held_duration = (stable_pressed && start_ms != '0) ? now - start_ms : '0;
        return r;
    endfunction

    // Sample driver: predicts on each accepted beat, holds a stalled beat steady.
    always @(posedge i_clk) begin : sample_driver
        logic taken;
        taken = i_in_valid && !o_in_stall;
        if (taken) begin
            expected_q.push_back(classify_sample(i_pin_level, i_now_ms));
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !taken) begin
            // stalled: valid and payload stay as they are
        end else if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            i_in_valid  <= 1'b1;
            i_pin_level <= sample_q[0].pin;
            i_now_ms    <= sample_q[0].now;
            void'(sample_q.pop_front());
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result monitor: checks each accepted beat against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected: event %0d pressed %0b held %0d",
                         $time, o_event_code, o_pressed_now, o_held_duration);
            end else begin
                want = expected_q.pop_front();
                if (o_event_code !== want.event_code) begin
                    mismatch_count++;
                    $display("%0t: event_code expected %0d actual %0d",
                             $time, want.event_code, o_event_code);
                end
                if (o_pressed_now !== want.pressed_now) begin
                    mismatch_count++;
                    $display("%0t: pressed_now expected %0b actual %0b",
                             $time, want.pressed_now, o_pressed_now);
                end
                if (o_held_duration !== want.held_duration) begin
                    mismatch_count++;
                    $display("%0t: held_duration expected %0d actual %0d",
                             $time, want.held_duration, o_held_duration);
                end
            end
        end
        i_out_stall <= i_rst_n && (out_hold || ($urandom_range(0, 99) < stall_pct));
    end

    // Long hold-off of the result side, counted here so the sender keeps going.
    always begin : long_hold
        @(hold_start);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Queue a sample by its pressed meaning under the current active level.
    task automatic push_level(logic pressed, logic [TS_W-1:0] t);
        t_pin_sample s;
        s.pin = pressed ? cfg_active : ~cfg_active;
        s.now = t;
        sample_q.push_back(s);
    endtask

    // Config beats go out back to back; valid drops once after the last one.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            REG_ACTIVE_LEVEL:  cfg_active   = data[0];
            REG_DEBOUNCE_TIME: cfg_debounce = data[DEB_W-1:0];
            REG_LONG_THRESH:   cfg_long     = data;
            REG_VLONG_THRESH:  cfg_vlong    = data;
            default: ;
        endcase
    endtask

    // Wait until nothing is queued, in flight or predicted, then let latency pass.
    task automatic wait_until_quiet();
        while (sample_q.size() != 0 || i_in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Phases 0-3 pin the corners: reset values, debounce and thresholds all zero,
    // debounce and thresholds all at their maximum, thresholds out of order. Later phases are random.
    task automatic configure_phase(int p);
        logic             al;
        logic [DEB_W-1:0] deb;
        logic [TS_W-1:0]  lt;
        logic [TS_W-1:0]  vlt;
        logic [31:0]      junk;
        case (p)
            0: begin al = 1'b0; deb = DEBOUNCE_RST; lt = LONG_THRESH_RST; vlt = VLONG_THRESH_RST; end
            1: begin al = 1'b1; deb = '0; lt = '0; vlt = '0; end
            2: begin al = 1'b0; deb = '1; lt = '1; vlt = '1; end
            3: begin al = 1'b1; deb = 16'd1; lt = 32'd3000; vlt = 32'd1000; end
            default: begin
                al  = 1'($urandom_range(0, 1));
                deb = DEB_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 120));
                lt  = $urandom_range(0, 4000);
                vlt = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 9000);
            end
        endcase
        junk = $urandom;
        // upper data bits carry junk that the narrow registers must drop
        write_reg(REG_ACTIVE_LEVEL, {junk[31:1], al});
        write_reg(REG_DEBOUNCE_TIME, {junk[31:16], deb});
        write_reg(REG_LONG_THRESH, lt);
        write_reg(REG_VLONG_THRESH, vlt);
        write_reg(REG_UNUSED + 8'($urandom_range(0, 251)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Press length, aimed at the threshold edges in four cases out of ten.
    function automatic logic [TS_W-1:0] pick_target();
        logic [TS_W-1:0] top;
        top = (cfg_vlong > cfg_long) ? cfg_vlong : cfg_long;
        case ($urandom_range(0, 9))
            0:       return cfg_long - 1;
            1:       return cfg_long;
            2:       return cfg_vlong - 1;
            3:       return cfg_vlong;
            4:       return $urandom;
            5:       return $urandom_range(0, 100);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // One press with bounce: the press edge is aimed to settle at t1 and the release at
    // t1 + target, so the classified duration is aimed at target.
    task automatic gen_press(logic [TS_W-1:0] target);
        logic [TS_W-1:0] d;
        logic [TS_W-1:0] t1;
        logic [TS_W-1:0] t2;
        logic [TS_W-1:0] t3;
        int              n;
        d = TS_W'(cfg_debounce);
        repeat ($urandom_range(0, 3)) begin
            push_level(1'($urandom_range(0, 1)), gen_ms);
            gen_ms += $urandom_range(1, 5);
        end
        push_level(1'b1, gen_ms);
        if (d != '0 && $urandom_range(0, 1))
            push_level(1'b1, gen_ms + d - 1);   // one short of settling
        t1 = gen_ms + d;
        push_level(1'b1, t1);
        t3 = t1 + target;
        t2 = t3 - d;
        n  = $urandom_range(0, 3);
        for (int k = 1; k <= n; k++)
            push_level(1'b1, t1 + (target / (n + 1)) * k);
        if ($urandom_range(0, 1)) begin
            push_level(1'b0, t2 - 3);
            push_level(1'b1, t2 - 2);
        end
        push_level(1'b0, t2);
        if (d != '0 && $urandom_range(0, 1))
            push_level(1'b0, t3 - 1);
        push_level(1'b0, t3);
        if ($urandom_range(0, 1))
            push_level(1'b0, t3 + $urandom_range(0, 100));
        gen_ms = t3 + $urandom_range(1, 200);
    endtask

    task automatic gen_beats(int count);
        int base;
        t_pin_sample s;
        base = sample_q.size();
        while (sample_q.size() - base < count) begin
            if ($urandom_range(0, 99) < 15) begin
                // raw noise, sometimes at a wild timestamp
                s.pin = 1'($urandom_range(0, 1));
                s.now = $urandom_range(0, 3) == 0 ? $urandom
                                                  : gen_ms + $urandom_range(0, 60);
                sample_q.push_back(s);
            end else begin
                gen_press(pick_target());
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, under reset configuration (active low, 50 / 1000 / 3000).
        push_level(1'b0, 32'h0000_0000);
        push_level(1'b0, 32'hFFFF_FFFF);
        push_level(1'b1, 32'hFFFF_FFCE);      // press edge just before the wrap
        push_level(1'b0, 32'hFFFF_FFD0);      // bounce
        push_level(1'b1, 32'hFFFF_FFCE);
        push_level(1'b1, 32'hFFFF_FFFF);      // one ms short of debounce
        push_level(1'b1, 32'h0000_0000);      // settles with start tick zero
        push_level(1'b1, 32'd500);            // pressed but duration reads 0
        push_level(1'b0, 32'd900);
        push_level(1'b0, 32'd950);            // short, measured from zero
        push_level(1'b1, 32'd1000);
        push_level(1'b1, 32'd1050);
        push_level(1'b1, 32'd2000);
        push_level(1'b0, 32'd2000);
        push_level(1'b0, 32'd2050);           // long, exactly on threshold
        push_level(1'b1, 32'd3000);
        push_level(1'b1, 32'd3050);
        push_level(1'b0, 32'd6000);
        push_level(1'b0, 32'd6050);           // very long, exactly on threshold
        push_level(1'b1, 32'hFFFF_FF00);
        push_level(1'b1, 32'hFFFF_FF32);
        push_level(1'b1, 32'h0000_0010);      // duration across the wrap
        push_level(1'b0, 32'h0000_0300);
        push_level(1'b0, 32'h0000_0332);      // long press spanning the wrap
        wait_until_quiet();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            configure_phase(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            gen_ms = $urandom;
            gen_beats(PHASE_BEATS);
            wait_until_quiet();
        end

        // Pressure: sender at full rate while the result side holds off long
        // enough for the block to fill and stall its input.
        configure_phase(PHASE_COUNT);
        send_idle_pct = 0;
        stall_pct     = 0;
        gen_ms        = $urandom;
        gen_beats(60);
        -> hold_start;
        wait_until_quiet();

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/dbpc_pkg.sv
design/dbpc_cfg_regs.sv
design/dbpc_core.sv
design/debounced_button_press_classifier.sv
tb/debounced_button_press_classifier_tb.sv
